>>> rtl/core/priority_schedule_wait_times_unit_defines.svh
// Assertion macros shared by the priority scheduler RTL.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`define PSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSW_ASSERT(lbl, prop, msg)

`define PSW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/psw_pkg.sv
// Shared types, widths and helpers of the priority scheduler.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package psw_pkg;

    localparam int unsigned PSW_MAX_JOBS = 16;

    localparam int unsigned BURST_W     = 16;
    localparam int unsigned PRIO_W      = 8;
    localparam int unsigned JOB_NUM_W   = 5;
    localparam int unsigned TIME_W      = 20;
    localparam int unsigned TOT_WAIT_W  = 23;
    localparam int unsigned TOT_TAT_W   = 24;
    localparam int unsigned AVG_W       = 28;
    localparam int unsigned FRAC_BITS   = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic sort_init;
        logic rd_i;
        logic load_cur;
        logic cmp_step;
        logic write_i;
        logic emit_init;
        logic rd_k;
        logic load_out;
        logic div_start;
        logic load_final;
        logic next_k;
        logic end_set;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_last;
        logic i_last;
        logic j_last;
        logic k_last;
        logic div_done;
    } t_status;

    // Clamp an unsigned value to the largest value of a w-bit field.
    function automatic logic [63:0] sat_u(input logic [63:0] v, input int unsigned w);
        logic [63:0] lim;
        lim = (64'd1 << w) - 64'd1;
        return (v > lim) ? lim : v;
    endfunction

endpackage

>>> rtl/core/priority_schedule_wait_times_unit.sv
// Non-preemptive priority scheduler: takes jobs one request per cycle while idle and
// stores them; the job marked last starts scheduling, during which input requests stall.
// The job table has one write port and one read port; the exchange sort works through it
// row by row, then each result is read, computed and presented, held while the output stalls,
// and the final result also waits for the two bit-serial average dividers of TW + 8 bits,
// TW being 16 + 2*clog2(MAX_JOBS).
// Top level; depends on psw_pkg, psw_ctrl, psw_dp and their submodules.
`timescale 1ns / 1ps

module priority_schedule_wait_times_unit #(
    parameter int unsigned MAX_JOBS = psw_pkg::PSW_MAX_JOBS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [psw_pkg::BURST_W-1:0]     i_burst,
    input  logic [psw_pkg::PRIO_W-1:0]      i_priority_req,
    input  logic                            i_is_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [psw_pkg::JOB_NUM_W-1:0]   o_job_number,
    output logic [psw_pkg::BURST_W-1:0]     o_job_burst,
    output logic [psw_pkg::TIME_W-1:0]      o_wait_time,
    output logic [psw_pkg::TIME_W-1:0]      o_turnaround,
    output logic [psw_pkg::TOT_WAIT_W-1:0]  o_total_wait,
    output logic [psw_pkg::TOT_TAT_W-1:0]   o_total_turnaround,
    output logic [psw_pkg::AVG_W-1:0]       o_avg_wait,
    output logic [psw_pkg::AVG_W-1:0]       o_avg_turnaround,
    output logic                            o_jobs_dropped,
    output logic                            o_last_result
);

    import psw_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    psw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    psw_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_burst            (i_burst),
        .i_priority_req     (i_priority_req),
        .i_is_last          (i_is_last),
        .o_job_number       (o_job_number),
        .o_job_burst        (o_job_burst),
        .o_wait_time        (o_wait_time),
        .o_turnaround       (o_turnaround),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_avg_wait         (o_avg_wait),
        .o_avg_turnaround   (o_avg_turnaround),
        .o_jobs_dropped     (o_jobs_dropped),
        .o_last_result      (o_last_result)
    );

endmodule

>>> rtl/core/psw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module psw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/psw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "priority_schedule_wait_times_unit_defines.svh"

module psw_div #(
    parameter int unsigned DW = 32,
    parameter int unsigned VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_div;
    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;

    logic [VW:0]      w_shifted;
    logic [VW:0]      w_diff;
    logic             w_ge;

    always_comb begin
        w_shifted = {r_rem, r_quo[DW-1]};
        w_diff    = w_shifted - {1'b0, r_div};
        w_ge      = (w_shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[VW-1:0] : w_shifted[VW-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `PSW_ASSERT_NEXT(a_done_single, r_done && !i_start, !r_done, "divider done held over a cycle")
    `PSW_ASSERT(a_done_after_busy, !r_done || !r_busy || i_start, "divider done while busy")
    `PSW_ASSERT_NEXT(a_start_sets_busy, i_start, r_busy && !r_done, "divider did not start")

endmodule

>>> rtl/core/psw_ctrl.sv
// Controller of the priority scheduler: load, exchange sort, emit, divide.
// Depends on psw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "priority_schedule_wait_times_unit_defines.svh"

module psw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  psw_pkg::t_status i_status,
    output psw_pkg::t_cmd    o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    import psw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_I,
        S_LOAD_CUR,
        S_CMP,
        S_WRITE_I,
        S_EMIT_RD,
        S_EMIT_CALC,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.store = 1'b1;
                    if (i_status.is_last) begin
                        w_cmd.sort_init = 1'b1;
                        n_state         = S_SORT_I;
                    end
                end
            end
            S_SORT_I: begin
                if (i_status.i_last) begin
                    w_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT_RD;
                end else begin
                    w_cmd.rd_i = 1'b1;
                    n_state    = S_LOAD_CUR;
                end
            end
            S_LOAD_CUR: begin
                w_cmd.load_cur = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                w_cmd.cmp_step = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_WRITE_I;
                end
            end
            S_WRITE_I: begin
                w_cmd.write_i = 1'b1;
                n_state       = S_SORT_I;
            end
            S_EMIT_RD: begin
                w_cmd.rd_k = 1'b1;
                n_state    = S_EMIT_CALC;
            end
            S_EMIT_CALC: begin
                w_cmd.load_out = 1'b1;
                n_state        = i_status.k_last ? S_DIV_START : S_OUT;
            end
            S_DIV_START: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    w_cmd.load_final = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_status.k_last) begin
                        w_cmd.end_set = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        w_cmd.next_k = 1'b1;
                        n_state      = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (n_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PSW_ASSERT(a_no_input_during_output, !r_out_valid || o_in_stall, "input ready while a result is pending")
    `PSW_ASSERT_NEXT(a_final_frees_input, r_out_valid && !i_out_stall && i_status.k_last, !o_in_stall && !r_out_valid, "set did not close after the final result")
    `PSW_ASSERT_NEXT(a_last_job_starts_sort, i_in_valid && !o_in_stall && i_status.is_last, o_in_stall, "last job did not start scheduling")

endmodule

>>> rtl/core/psw_dp.sv
// Datapath of the priority scheduler: job table, sort registers, time sums, dividers.
// Depends on psw_pkg, psw_ram, psw_div and the assertion macro header.
`timescale 1ns / 1ps
`include "priority_schedule_wait_times_unit_defines.svh"

module psw_dp #(
    parameter int unsigned MAX_JOBS = psw_pkg::PSW_MAX_JOBS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psw_pkg::t_cmd                   i_cmd,
    output psw_pkg::t_status                o_status,
    input  logic [psw_pkg::BURST_W-1:0]     i_burst,
    input  logic [psw_pkg::PRIO_W-1:0]      i_priority_req,
    input  logic                            i_is_last,
    output logic [psw_pkg::JOB_NUM_W-1:0]   o_job_number,
    output logic [psw_pkg::BURST_W-1:0]     o_job_burst,
    output logic [psw_pkg::TIME_W-1:0]      o_wait_time,
    output logic [psw_pkg::TIME_W-1:0]      o_turnaround,
    output logic [psw_pkg::TOT_WAIT_W-1:0]  o_total_wait,
    output logic [psw_pkg::TOT_TAT_W-1:0]   o_total_turnaround,
    output logic [psw_pkg::AVG_W-1:0]       o_avg_wait,
    output logic [psw_pkg::AVG_W-1:0]       o_avg_turnaround,
    output logic                            o_jobs_dropped,
    output logic                            o_last_result
);

    import psw_pkg::*;

    localparam int unsigned AW = $clog2(MAX_JOBS);
    localparam int unsigned CW = $clog2(MAX_JOBS + 1);
    localparam int unsigned EW = CW + PRIO_W + BURST_W;
    localparam int unsigned WW = BURST_W + $clog2(MAX_JOBS);
    localparam int unsigned TW = BURST_W + 2 * $clog2(MAX_JOBS);
    localparam int unsigned DW = TW + FRAC_BITS;
    localparam int unsigned PRIO_LO = BURST_W;
    localparam int unsigned NUM_LO  = BURST_W + PRIO_W;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_k;
    logic [EW-1:0] r_cur;
    logic [WW-1:0] r_wait;
    logic [TW-1:0] r_tot_w;
    logic [TW-1:0] r_tot_t;

    logic [JOB_NUM_W-1:0]  r_job_number;
    logic [BURST_W-1:0]    r_job_burst;
    logic [TIME_W-1:0]     r_wait_time;
    logic [TIME_W-1:0]     r_turnaround;
    logic [TOT_WAIT_W-1:0] r_total_wait;
    logic [TOT_TAT_W-1:0]  r_total_tat;
    logic [AVG_W-1:0]      r_avg_wait;
    logic [AVG_W-1:0]      r_avg_tat;
    logic                  r_dropped;
    logic                  r_last;

    logic          w_full;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [EW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [EW-1:0] w_rd_data;
    logic          w_swap;
    logic [CW-1:0] w_num_new;

    logic [WW-1:0] w_tat;
    logic [TW-1:0] w_sum_w;
    logic [TW-1:0] w_sum_t;
    logic [63:0]   w_sat_num;
    logic [63:0]   w_sat_wait;
    logic [63:0]   w_sat_tat;
    logic [63:0]   w_sat_tot_w;
    logic [63:0]   w_sat_tot_t;
    logic [63:0]   w_sat_avg_w;
    logic [63:0]   w_sat_avg_t;

    logic          w_done_w;
    logic          w_done_t;
    logic [DW-1:0] w_quo_w;
    logic [DW-1:0] w_quo_t;

    always_comb begin
        w_full    = (r_count >= CW'(MAX_JOBS));
        w_num_new = r_count + CW'(1);
        w_swap    = (r_cur[PRIO_LO +: PRIO_W] > w_rd_data[PRIO_LO +: PRIO_W]);

        w_wr_en   = 1'b0;
        w_wr_addr = r_i;
        w_wr_data = r_cur;
        if (i_cmd.store) begin
            w_wr_en   = !w_full;
            w_wr_addr = r_count[AW-1:0];
            w_wr_data = {w_num_new, i_priority_req, i_burst};
        end else if (i_cmd.cmp_step) begin
            // The entry at j takes the held entry when it is swapped out.
            w_wr_en   = w_swap;
            w_wr_addr = r_j;
        end else if (i_cmd.write_i) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_i;
        end

        w_rd_en   = 1'b0;
        w_rd_addr = r_k;
        if (i_cmd.rd_i) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_i;
        end else if (i_cmd.load_cur) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_i + AW'(1);
        end else if (i_cmd.cmp_step) begin
            w_rd_en   = !o_status.j_last;
            w_rd_addr = r_j + AW'(1);
        end else if (i_cmd.rd_k) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_k;
        end

        w_tat   = r_wait + WW'(w_rd_data[BURST_W-1:0]);
        w_sum_w = r_tot_w + TW'(r_wait);
        w_sum_t = r_tot_t + TW'(w_tat);

        w_sat_num   = sat_u(64'(w_rd_data[NUM_LO +: CW]), JOB_NUM_W);
        w_sat_wait  = sat_u(64'(r_wait), TIME_W);
        w_sat_tat   = sat_u(64'(w_tat), TIME_W);
        w_sat_tot_w = sat_u(64'(r_tot_w), TOT_WAIT_W);
        w_sat_tot_t = sat_u(64'(r_tot_t), TOT_TAT_W);
        w_sat_avg_w = sat_u(64'(w_quo_w), AVG_W);
        w_sat_avg_t = sat_u(64'(w_quo_t), AVG_W);

        o_status.is_last  = i_is_last;
        o_status.i_last   = ((CW'(r_i) + CW'(1)) >= r_count);
        o_status.j_last   = ((CW'(r_j) + CW'(1)) >= r_count);
        o_status.k_last   = ((CW'(r_k) + CW'(1)) >= r_count);
        o_status.div_done = w_done_w && w_done_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= w_num_new;
                end
            end else if (i_cmd.end_set) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= '0;
        end else if (i_cmd.write_i) begin
            r_i <= r_i + AW'(1);
        end

        if (i_cmd.load_cur) begin
            r_cur <= w_rd_data;
            r_j   <= r_i + AW'(1);
        end else if (i_cmd.cmp_step) begin
            if (w_swap) begin
                r_cur <= w_rd_data;
            end
            if (!o_status.j_last) begin
                r_j <= r_j + AW'(1);
            end
        end

        if (i_cmd.emit_init) begin
            r_k     <= '0;
            r_wait  <= '0;
            r_tot_w <= '0;
            r_tot_t <= '0;
        end else if (i_cmd.next_k) begin
            r_k <= r_k + AW'(1);
        end else if (i_cmd.load_out) begin
            r_wait  <= w_tat;
            r_tot_w <= w_sum_w;
            r_tot_t <= w_sum_t;
        end

        if (i_cmd.load_out) begin
            r_job_number <= w_sat_num[JOB_NUM_W-1:0];
            r_job_burst  <= w_rd_data[BURST_W-1:0];
            r_wait_time  <= w_sat_wait[TIME_W-1:0];
            r_turnaround <= w_sat_tat[TIME_W-1:0];
            r_total_wait <= '0;
            r_total_tat  <= '0;
            r_avg_wait   <= '0;
            r_avg_tat    <= '0;
            r_dropped    <= 1'b0;
            r_last       <= 1'b0;
        end else if (i_cmd.load_final) begin
            r_total_wait <= w_sat_tot_w[TOT_WAIT_W-1:0];
            r_total_tat  <= w_sat_tot_t[TOT_TAT_W-1:0];
            r_avg_wait   <= w_sat_avg_w[AVG_W-1:0];
            r_avg_tat    <= w_sat_avg_t[AVG_W-1:0];
            r_dropped    <= r_ovf;
            r_last       <= 1'b1;
        end
    end

    psw_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    psw_div #(
        .DW (DW),
        .VW (CW)
    ) u_div_wait (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_tot_w, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_count),
        .o_done     (w_done_w),
        .o_quotient (w_quo_w)
    );

    psw_div #(
        .DW (DW),
        .VW (CW)
    ) u_div_tat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_tot_t, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_count),
        .o_done     (w_done_t),
        .o_quotient (w_quo_t)
    );

    assign o_job_number       = r_job_number;
    assign o_job_burst        = r_job_burst;
    assign o_wait_time        = r_wait_time;
    assign o_turnaround       = r_turnaround;
    assign o_total_wait       = r_total_wait;
    assign o_total_turnaround = r_total_tat;
    assign o_avg_wait         = r_avg_wait;
    assign o_avg_turnaround   = r_avg_tat;
    assign o_jobs_dropped     = r_dropped;
    assign o_last_result      = r_last;

    `PSW_ASSERT(a_count_in_range, r_count <= CW'(MAX_JOBS), "job count beyond table size")
    `PSW_ASSERT_NEXT(a_tat_not_below_wait, i_cmd.load_out, r_turnaround >= r_wait_time, "turnaround below waiting time")
    `PSW_ASSERT(a_dividers_in_step, w_done_w == w_done_t, "average dividers out of step")

endmodule

>>> sim/tb_priority_schedule_wait_times_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for priority_schedule_wait_times_unit: feeds job sets through the
// request port and compares every scheduled job with a behavioral priority schedule.
// Depends on psw_pkg and the scheduler RTL only.

module tb_priority_schedule_wait_times_unit;
    import psw_pkg::*;

    localparam int unsigned TABLE_DEPTH      = PSW_MAX_JOBS;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned TAIL_CYCLES      = 64;
    localparam int unsigned LONG_HOLD_CYCLES = 400;

    typedef struct {
        logic [JOB_NUM_W-1:0]  job_number;
        logic [BURST_W-1:0]    job_burst;
        logic [TIME_W-1:0]     wait_time;
        logic [TIME_W-1:0]     turnaround;
        logic [TOT_WAIT_W-1:0] total_wait;
        logic [TOT_TAT_W-1:0]  total_turnaround;
        logic [AVG_W-1:0]      avg_wait;
        logic [AVG_W-1:0]      avg_turnaround;
        logic                  jobs_dropped;
        logic                  last_result;
    } t_sched_entry;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BURST_W-1:0]    i_burst;
    logic [PRIO_W-1:0]     i_priority_req;
    logic                  i_is_last;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [JOB_NUM_W-1:0]  o_job_number;
    logic [BURST_W-1:0]    o_job_burst;
    logic [TIME_W-1:0]     o_wait_time;
    logic [TIME_W-1:0]     o_turnaround;
    logic [TOT_WAIT_W-1:0] o_total_wait;
    logic [TOT_TAT_W-1:0]  o_total_turnaround;
    logic [AVG_W-1:0]      o_avg_wait;
    logic [AVG_W-1:0]      o_avg_turnaround;
    logic                  o_jobs_dropped;
    logic                  o_last_result;

    // Jobs of the set being loaded, in arrival order.
    logic [BURST_W-1:0]    loaded_burst[TABLE_DEPTH];
    logic [PRIO_W-1:0]     loaded_prio[TABLE_DEPTH];
    logic [JOB_NUM_W-1:0]  loaded_number[TABLE_DEPTH];
    int unsigned           loaded_count;
    bit                    set_overflowed;

    t_sched_entry          scheduled_jobs_q[$];

    bit                    idle_on;
    bit                    hold_active = 1'b0;
    int unsigned           out_gap_left = 0;
    int unsigned           jobs_sent;
    int unsigned           cycle_count;
    int                    error_count;
    event                  long_hold_ev;

    priority_schedule_wait_times_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_burst            (i_burst),
        .i_priority_req     (i_priority_req),
        .i_is_last          (i_is_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_job_number       (o_job_number),
        .o_job_burst        (o_job_burst),
        .o_wait_time        (o_wait_time),
        .o_turnaround       (o_turnaround),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_avg_wait         (o_avg_wait),
        .o_avg_turnaround   (o_avg_turnaround),
        .o_jobs_dropped     (o_jobs_dropped),
        .o_last_result      (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] clip_to_width(input logic [63:0] v, input int unsigned w);
        logic [63:0] top;
        top = (64'd1 << w) - 64'd1;
        if (v > top) return top;
        return v;
    endfunction

    // Stores one job; the job marked last sorts the set and queues its schedule.
    function automatic void load_job_and_schedule(input logic [BURST_W-1:0] burst,
                                                  input logic [PRIO_W-1:0] prio,
                                                  input logic last);
        t_sched_entry          rows[TABLE_DEPTH];
        logic [BURST_W-1:0]    b_swap;
        logic [PRIO_W-1:0]     p_swap;
        logic [JOB_NUM_W-1:0]  n_swap;
        logic [63:0]           run_wait;
        logic [63:0]           run_tat;
        logic [63:0]           sum_wait;
        logic [63:0]           sum_tat;
        int unsigned           n;
        int unsigned           a;
        int unsigned           b;

        if (loaded_count < TABLE_DEPTH) begin
            loaded_burst[loaded_count]  = burst;
            loaded_prio[loaded_count]   = prio;
            loaded_number[loaded_count] = JOB_NUM_W'(loaded_count + 1);
            loaded_count++;
        end else begin
            set_overflowed = 1'b1;
        end
        if (!last) return;

        n = loaded_count;
        // Exchange sort: ties end up in whatever order these swaps leave them.
        for (a = 0; a + 1 < n; a++) begin
            for (b = a + 1; b < n; b++) begin
                if (loaded_prio[a] > loaded_prio[b]) begin
                    b_swap = loaded_burst[a];
                    p_swap = loaded_prio[a];
                    n_swap = loaded_number[a];
                    loaded_burst[a]  = loaded_burst[b];
                    loaded_prio[a]   = loaded_prio[b];
                    loaded_number[a] = loaded_number[b];
                    loaded_burst[b]  = b_swap;
                    loaded_prio[b]   = p_swap;
                    loaded_number[b] = n_swap;
                end
            end
        end

        run_wait = 0;
        sum_wait = 0;
        sum_tat  = 0;
        for (a = 0; a < n; a++) begin
            run_tat = run_wait + 64'(loaded_burst[a]);
            sum_wait += run_wait;
            sum_tat  += run_tat;
            rows[a] = '{job_number: JOB_NUM_W'(clip_to_width(64'(loaded_number[a]),
                                                             JOB_NUM_W)),
                        job_burst: loaded_burst[a],
                        wait_time: TIME_W'(clip_to_width(run_wait, TIME_W)),
                        turnaround: TIME_W'(clip_to_width(run_tat, TIME_W)),
                        total_wait: '0, total_turnaround: '0,
                        avg_wait: '0, avg_turnaround: '0,
                        jobs_dropped: 1'b0, last_result: 1'b0};
            run_wait = run_tat;
        end
        rows[n-1].total_wait       = TOT_WAIT_W'(clip_to_width(sum_wait, TOT_WAIT_W));
        rows[n-1].total_turnaround = TOT_TAT_W'(clip_to_width(sum_tat, TOT_TAT_W));
        rows[n-1].avg_wait         = AVG_W'(clip_to_width((sum_wait << FRAC_BITS) / 64'(n),
                                                          AVG_W));
        rows[n-1].avg_turnaround   = AVG_W'(clip_to_width((sum_tat << FRAC_BITS) / 64'(n),
                                                          AVG_W));
        rows[n-1].jobs_dropped     = set_overflowed;
        rows[n-1].last_result      = 1'b1;
        for (a = 0; a < n; a++) scheduled_jobs_q.push_back(rows[a]);

        loaded_count   = 0;
        set_overflowed = 1'b0;
    endfunction

    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? '1 : '0;
            1:       return BURST_W'($urandom_range(0, 255));
            default: return BURST_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                            input logic last);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_burst        <= burst;
        i_priority_req <= prio;
        i_is_last      <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        load_job_and_schedule(burst, prio, last);
        jobs_sent++;
    endtask

    task automatic wait_schedule_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (scheduled_jobs_q.size() != 0);
    endtask

    task automatic run_random_sets(input int unsigned job_total);
        int unsigned stop_at;
        int unsigned len;
        int unsigned prio_span;
        int unsigned k;
        stop_at = jobs_sent + job_total;
        while (jobs_sent < stop_at) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 4)
                                              : $urandom_range(1, TABLE_DEPTH);
            // A narrow priority range makes ties common.
            prio_span = ($urandom_range(0, 2) == 0) ? 3 : 255;
            for (k = 0; k < len; k++)
                send_job(pick_burst(), PRIO_W'($urandom_range(0, prio_span)), k == len - 1);
            if ($urandom_range(0, 3) == 0) wait_schedule_drained();
        end
    endtask

    task automatic test_single_job();
        send_job('1, '1, 1'b1);
    endtask

    task automatic test_ties_and_zero_burst();
        send_job('0, 8'd7, 1'b0);
        send_job(16'd5, 8'd7, 1'b0);
        send_job('0, 8'd7, 1'b1);
    endtask

    task automatic test_priority_extremes();
        send_job(16'd100, 8'd255, 1'b0);
        send_job(16'd200, 8'd128, 1'b0);
        send_job(16'd1, 8'd0, 1'b0);
        send_job(16'd300, 8'd1, 1'b1);
    endtask

    // A full table of longest bursts, then one extra job and a last job, both dropped.
    task automatic test_table_overflow();
        int unsigned k;
        for (k = 0; k < TABLE_DEPTH; k++) send_job('1, PRIO_W'($urandom_range(0, 255)), 1'b0);
        send_job(16'd1234, 8'd0, 1'b0);
        send_job(16'd4321, 8'd0, 1'b1);
        wait_schedule_drained();
    endtask

    // The receiver holds off while sets keep coming, so the input has to stall.
    task automatic test_output_backpressure();
        int unsigned s;
        int unsigned k;
        idle_on = 1'b0;
        -> long_hold_ev;
        for (s = 0; s < 5; s++)
            for (k = 0; k < 4; k++)
                send_job(pick_burst(), PRIO_W'($urandom_range(0, 255)), k == 3);
        idle_on = 1'b1;
        wait_schedule_drained();
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        run_random_sets(50);
        idle_on = 1'b1;
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sched_entry want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scheduled_jobs_q.size() == 0) begin
                $error("unexpected result for job %0d", o_job_number);
                error_count++;
            end else begin
                want = scheduled_jobs_q.pop_front();
                compare_field("job_number", 32'(want.job_number), 32'(o_job_number));
                compare_field("job_burst", 32'(want.job_burst), 32'(o_job_burst));
                compare_field("wait_time", 32'(want.wait_time), 32'(o_wait_time));
                compare_field("turnaround", 32'(want.turnaround), 32'(o_turnaround));
                compare_field("total_wait", 32'(want.total_wait), 32'(o_total_wait));
                compare_field("total_turnaround", 32'(want.total_turnaround),
                              32'(o_total_turnaround));
                compare_field("avg_wait", 32'(want.avg_wait), 32'(o_avg_wait));
                compare_field("avg_turnaround", 32'(want.avg_turnaround),
                              32'(o_avg_turnaround));
                compare_field("jobs_dropped", 32'(want.jobs_dropped), 32'(o_jobs_dropped));
                compare_field("last_result", 32'(want.last_result), 32'(o_last_result));
            end
        end
    end

    // After each taken result the receiver may stall a random gap while idle_on is set.
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && !i_out_stall)
            out_gap_left = idle_on ? $urandom_range(0, 9) : 0;
        else if (out_gap_left != 0)
            out_gap_left = out_gap_left - 1;
        i_out_stall <= hold_active || (out_gap_left != 0);
    end

    initial begin
        forever begin
            @(long_hold_ev);
            hold_active <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_burst        <= '0;
        i_priority_req <= '0;
        i_is_last      <= 1'b0;
        idle_on        = 1'b1;
        error_count    = 0;
        jobs_sent      = 0;
        loaded_count   = 0;
        set_overflowed = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_job();
        test_ties_and_zero_burst();
        test_priority_extremes();
        test_table_overflow();
        run_random_sets(230);
        test_output_backpressure();
        test_streaming();

        wait_schedule_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (scheduled_jobs_q.size() != 0) begin
            $error("%0d scheduled jobs never came out", scheduled_jobs_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
